### rtl/core/svk_pkg.sv
// Shared types and constants for the SVM kernel evaluator.
// Used by the controller, the datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none
package svk_pkg;

   localparam logic [1:0] MODE_LINEAR = 2'd0;
   localparam logic [1:0] MODE_RBF    = 2'd1;
   localparam logic [1:0] MODE_POLY   = 2'd2;

   localparam logic [1:0] CSR_KERNEL_MODE = 2'd0;
   localparam logic [1:0] CSR_GAMMA_SCALE = 2'd1;
   localparam logic [1:0] CSR_POLY_DEGREE = 2'd2;
   localparam logic [1:0] CSR_POLY_OFFSET = 2'd3;

   localparam logic [3:0]  MAX_DEGREE  = 4'd15;
   localparam logic [21:0] LN2_Q16     = 22'd45426;
   localparam logic [21:0] T_CAP       = 22'd2097152;
   localparam logic [16:0] ONE_Q16     = 17'd65536;
   localparam logic [4:0]  K_LIMIT     = 5'd16;
   localparam logic [33:0] RECIP3      = 34'd43691;
   localparam logic [33:0] RECIP5      = 34'd52429;

   typedef enum logic [1:0] {
      OUT_LINEAR,
      OUT_RBF,
      OUT_POLY
   } out_sel_type;

   typedef enum logic [3:0] {
      ST_ACC,
      ST_RBF_HI,
      ST_RBF_LO,
      ST_RBF_T,
      ST_RBF_DIV,
      ST_H_MUL,
      ST_H_STEP,
      ST_POLY_INIT,
      ST_POLY_PP,
      ST_POLY_FIN,
      ST_WRITE
   } state_type;

   typedef struct packed {
      logic        acc_en;
      logic        acc_clear;
      logic        rbf_hi;
      logic        rbf_lo;
      logic        rbf_t;
      logic        div_step;
      logic        h_mul;
      logic        h_step;
      logic [2:0]  h_div;
      logic        poly_init;
      logic        poly_pp;
      logic [1:0]  pp_idx;
      logic        poly_fin;
      logic        out_load;
      out_sel_type out_sel;
   } cmd_type;

   typedef struct packed {
      logic       div_done;
      logic [1:0] mode;
      logic [3:0] degree;
   } status_type;

endpackage
`default_nettype wire

### rtl/core/svk_ifs.sv
// Stream interfaces for the request and response channels.
// Depends on nothing but the port widths of the evaluator.
`timescale 1ns / 1ps
`default_nettype none
interface svk_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] x_elem;
   logic signed [15:0] y_elem;
   logic               last_elem;
   modport source (output valid, x_elem, y_elem, last_elem, input ready);
   modport sink (input valid, x_elem, y_elem, last_elem, output ready);
endinterface

interface svk_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [63:0] kernel_value;
   logic               saturated;
   modport source (output valid, kernel_value, saturated, input ready);
   modport sink (input valid, kernel_value, saturated, output ready);
endinterface
`default_nettype wire

### rtl/core/svk_ctrl.sv
// Controller state machine of the kernel evaluator.
// Depends on svk_pkg; drives the datapath by command structs.
`timescale 1ns / 1ps
`default_nettype none
module svk_ctrl
   import svk_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  req_valid,
   input  wire logic  req_last,
   output logic       req_ready,
   output logic       rsp_valid,
   input  wire logic  rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type   state_ff, state_in;
   logic [1:0]  pp_ff, pp_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic [3:0]  deg_ff, deg_in;
   out_sel_type sel_ff, sel_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        accept;
   logic        can_load;
   logic [3:0]  degree_eff;

   assign accept     = (state_ff == ST_ACC) && req_valid;
   assign can_load   = !rsp_valid_ff || rsp_ready;
   assign degree_eff = (status.degree > MAX_DEGREE) ? MAX_DEGREE : status.degree;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_ACC: begin
            if (accept && req_last) begin
               if (status.mode == MODE_RBF) state_in = ST_RBF_HI;
               else if (status.mode == MODE_POLY) state_in = ST_POLY_INIT;
               else state_in = ST_WRITE;
            end
         end
         ST_RBF_HI:  state_in = ST_RBF_LO;
         ST_RBF_LO:  state_in = ST_RBF_T;
         ST_RBF_T:   state_in = ST_RBF_DIV;
         ST_RBF_DIV: if (status.div_done) state_in = ST_H_MUL;
         ST_H_MUL:   state_in = ST_H_STEP;
         ST_H_STEP:  state_in = (cnt_ff == 3'd1) ? ST_WRITE : ST_H_MUL;
         ST_POLY_INIT: state_in = (degree_eff == 4'd0) ? ST_WRITE : ST_POLY_PP;
         ST_POLY_PP: if (pp_ff == 2'd3) state_in = ST_POLY_FIN;
         ST_POLY_FIN: state_in = (deg_ff == 4'd1) ? ST_WRITE : ST_POLY_PP;
         ST_WRITE:   if (can_load) state_in = ST_ACC;
         default:    state_in = ST_ACC;
      endcase
   end

   always_comb begin
      cmd         = '0;
      cmd.out_sel = sel_ff;
      cmd.h_div   = cnt_ff;
      cmd.pp_idx  = pp_ff;
      req_ready   = 1'b0;
      unique case (state_ff)
         ST_ACC: begin
            req_ready  = 1'b1;
            cmd.acc_en = accept;
         end
         ST_RBF_HI:    cmd.rbf_hi = 1'b1;
         ST_RBF_LO:    cmd.rbf_lo = 1'b1;
         ST_RBF_T:     cmd.rbf_t = 1'b1;
         ST_RBF_DIV:   cmd.div_step = 1'b1;
         ST_H_MUL:     cmd.h_mul = 1'b1;
         ST_H_STEP:    cmd.h_step = 1'b1;
         ST_POLY_INIT: cmd.poly_init = 1'b1;
         ST_POLY_PP:   cmd.poly_pp = 1'b1;
         ST_POLY_FIN:  cmd.poly_fin = 1'b1;
         ST_WRITE: begin
            cmd.out_load  = can_load;
            cmd.acc_clear = can_load;
         end
         default: ;
      endcase
   end

   always_comb begin
      pp_in        = pp_ff;
      cnt_in       = cnt_ff;
      deg_in       = deg_ff;
      sel_in       = sel_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (accept && req_last) begin
         if (status.mode == MODE_RBF) sel_in = OUT_RBF;
         else if (status.mode == MODE_POLY) sel_in = OUT_POLY;
         else sel_in = OUT_LINEAR;
      end
      if (state_ff == ST_RBF_T) cnt_in = 3'd5;
      if (state_ff == ST_H_STEP) cnt_in = cnt_ff - 3'd1;
      if (state_ff == ST_POLY_INIT) begin
         deg_in = degree_eff;
         pp_in  = 2'd0;
      end
      if (state_ff == ST_POLY_PP) pp_in = pp_ff + 2'd1;
      if (state_ff == ST_POLY_FIN) deg_in = deg_ff - 4'd1;
      if (state_ff == ST_WRITE && can_load) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_ACC;
         pp_ff        <= 2'd0;
         cnt_ff       <= 3'd0;
         deg_ff       <= 4'd0;
         sel_ff       <= OUT_LINEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pp_ff        <= pp_in;
         cnt_ff       <= cnt_in;
         deg_ff       <= deg_in;
         sel_ff       <= sel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

### rtl/core/svk_dp.sv
// Datapath of the kernel evaluator: configuration registers, accumulator,
// exponential and power units, and the result register. Depends on svk_pkg.
`timescale 1ns / 1ps
`default_nettype none
module svk_dp
   import svk_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_we,
   input  wire logic [1:0]         csr_index,
   input  wire logic [31:0]        csr_data,
   input  wire logic signed [15:0] x_elem,
   input  wire logic signed [15:0] y_elem,
   input  cmd_type                 cmd,
   output status_type              status,
   output logic signed [63:0]      kernel_value,
   output logic                    saturated
);

   logic [1:0]  mode_ff;
   logic [23:0] gamma_ff;
   logic [3:0]  degree_ff;
   logic [31:0] offset_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_LINEAR;
         gamma_ff  <= 24'd65536;
         degree_ff <= 4'd2;
         offset_ff <= 32'd65536;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_KERNEL_MODE: mode_ff   <= csr_data[1:0];
            CSR_GAMMA_SCALE: gamma_ff  <= csr_data[23:0];
            CSR_POLY_DEGREE: degree_ff <= csr_data[3:0];
            CSR_POLY_OFFSET: offset_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Accumulation of products or squared differences.
   logic [47:0]        acc_ff, acc_in;
   logic               ovf_ff, ovf_in;
   logic signed [16:0] xe, ye, diff, ma, mb;
   logic signed [33:0] term;
   logic signed [49:0] sum;

   assign xe   = {x_elem[15], x_elem};
   assign ye   = {y_elem[15], y_elem};
   assign diff = xe - ye;
   assign ma   = (mode_ff == MODE_RBF) ? diff : xe;
   assign mb   = (mode_ff == MODE_RBF) ? diff : ye;
   assign term = ma * mb;
   assign sum  = {{2{acc_ff[47]}}, acc_ff} + {{16{term[33]}}, term};

   always_comb begin
      acc_in = acc_ff;
      ovf_in = ovf_ff;
      if (cmd.acc_clear) begin
         acc_in = '0;
         ovf_in = 1'b0;
      end else if (cmd.acc_en) begin
         if (!sum[49] && sum[48:47] != 2'b00) begin
            acc_in = {1'b0, {47{1'b1}}};
            ovf_in = 1'b1;
         end else if (sum[49] && sum[48:47] != 2'b11) begin
            acc_in = {1'b1, 47'd0};
            ovf_in = 1'b1;
         end else begin
            acc_in = sum[47:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         ovf_ff <= 1'b0;
      end else begin
         acc_ff <= acc_in;
         ovf_ff <= ovf_in;
      end
   end

   // Exponential: scaled sum, range reduction by ln 2, then Horner steps.
   logic [46:0] s_pos;
   logic [46:0] ghi_ff;
   logic [47:0] glo_ff;
   logic [48:0] tsum;
   logic [32:0] tq;
   logic [21:0] t_ff, t_in;
   logic [4:0]  k_ff, k_in;
   logic [16:0] p_ff, p_in;
   logic [32:0] hp_ff;
   logic [15:0] q16, quo;
   logic [33:0] d3, d5;

   assign s_pos = acc_ff[47] ? 47'd0 : acc_ff[46:0];
   assign tsum  = {12'd0, ghi_ff[12:0], 24'd0} + {1'b0, glo_ff};
   assign tq    = tsum[48:16];
   assign q16   = hp_ff[31:16];
   assign d3    = {18'd0, q16} * RECIP3;
   assign d5    = {18'd0, q16} * RECIP5;

   always_comb begin
      unique case (cmd.h_div)
         3'd2:    quo = q16 >> 1;
         3'd3:    quo = d3[32:17];
         3'd4:    quo = q16 >> 2;
         3'd5:    quo = d5[33:18];
         default: quo = q16;
      endcase
   end

   assign status.div_done = (t_ff < LN2_Q16) || (k_ff > K_LIMIT);
   assign status.mode     = mode_ff;
   assign status.degree   = degree_ff;

   always_comb begin
      t_in = t_ff;
      k_in = k_ff;
      p_in = p_ff;
      if (cmd.rbf_t) begin
         if ((|ghi_ff[46:13]) || tq > {11'd0, T_CAP}) t_in = T_CAP;
         else t_in = tq[21:0];
         k_in = 5'd0;
         p_in = ONE_Q16;
      end else if (cmd.div_step && !status.div_done) begin
         t_in = t_ff - LN2_Q16;
         k_in = k_ff + 5'd1;
      end else if (cmd.h_step) begin
         p_in = ONE_Q16 - {1'b0, quo};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rbf_hi) ghi_ff <= {23'd0, gamma_ff} * {24'd0, s_pos[46:24]};
      if (cmd.rbf_lo) glo_ff <= {24'd0, gamma_ff} * {24'd0, s_pos[23:0]};
      if (cmd.h_mul) hp_ff <= {17'd0, t_ff[15:0]} * {16'd0, p_ff};
      t_ff <= t_in;
      k_ff <= k_in;
      p_ff <= p_in;
   end

   // Power: repeated Q.16 products, each built from four 32x32 parts.
   logic [63:0]  base;
   logic [63:0]  bmag_ff;
   logic         bneg_ff;
   logic [63:0]  res_ff;
   logic         psat_ff;
   logic [63:0]  rmag;
   logic [31:0]  opa, opb;
   logic [63:0]  pp;
   logic [127:0] pp_ext;
   logic [127:0] prod_ff;
   logic         pneg;
   logic [63:0]  qv, lim, qm;
   logic         over;

   assign base   = {{16{acc_ff[47]}}, acc_ff} + {{32{offset_ff[31]}}, offset_ff};
   assign rmag   = res_ff[63] ? (64'd0 - res_ff) : res_ff;
   assign opa    = cmd.pp_idx[1] ? rmag[63:32] : rmag[31:0];
   assign opb    = cmd.pp_idx[0] ? bmag_ff[63:32] : bmag_ff[31:0];
   assign pp     = {32'd0, opa} * {32'd0, opb};
   assign pneg   = res_ff[63] ^ bneg_ff;
   assign qv     = prod_ff[79:16];
   assign lim    = pneg ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
   assign over   = (|prod_ff[127:80]) || (qv > lim);
   assign qm     = over ? lim : qv;

   always_comb begin
      unique case (cmd.pp_idx)
         2'd0:    pp_ext = {64'd0, pp};
         2'd3:    pp_ext = {pp, 64'd0};
         default: pp_ext = {32'd0, pp, 32'd0};
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.poly_init) begin
         bneg_ff <= base[63];
         bmag_ff <= base[63] ? (64'd0 - base) : base;
         res_ff  <= {47'd0, ONE_Q16};
         psat_ff <= 1'b0;
      end else if (cmd.poly_fin) begin
         res_ff  <= pneg ? (64'd0 - qm) : qm;
         psat_ff <= psat_ff | over;
      end
      if (cmd.poly_pp) begin
         prod_ff <= ((cmd.pp_idx == 2'd0) ? 128'd0 : prod_ff) + pp_ext;
      end
   end

   // Result register.
   logic [63:0] rbf_val;

   assign rbf_val = (k_ff > K_LIMIT) ? 64'd0 : ({47'd0, p_ff} >> k_ff);

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         unique case (cmd.out_sel)
            OUT_RBF: begin
               kernel_value <= rbf_val;
               saturated    <= ovf_ff;
            end
            OUT_POLY: begin
               kernel_value <= res_ff;
               saturated    <= ovf_ff | psat_ff;
            end
            default: begin
               kernel_value <= {{16{acc_ff[47]}}, acc_ff};
               saturated    <= ovf_ff;
            end
         endcase
      end
   end

endmodule
`default_nettype wire

### rtl/core/svm_kernel_evaluator.sv
// Top level of the SVM kernel evaluator: controller plus datapath.
// Depends on svk_pkg, svk_ifs, svk_ctrl and svk_dp.
//
//   Channel  Direction  Contents
//   req      in         x_elem, y_elem, last_elem
//   rsp      out        kernel_value, saturated
//   csr      in         write enable, index, 32-bit data
//
// Elements are taken one item per cycle while the accumulator runs.
// After the last item, linear mode goes straight to the write state; RBF mode
// scales the sum in high and low halves, then takes one ln 2 reduction step per
// unit of k (up to 17), then Horner steps; polynomial mode takes the partial
// products and a finish per degree step of the four-part 64-bit multiplier.
// The result register holds an item while new elements already accumulate;
// a stalled response stalls only the next finish. Reset is synchronous.
`timescale 1ns / 1ps
`default_nettype none
module svm_kernel_evaluator
   import svk_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   svk_req_if.sink         req,
   svk_rsp_if.source       rsp,
   input wire logic        csr_we,
   input wire logic [1:0]  csr_index,
   input wire logic [31:0] csr_data
);

   cmd_type    cmd;
   status_type status;
   logic       req_ready;
   logic       rsp_valid;

   svk_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_last  (req.last_elem),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp.ready),
      .status    (status),
      .cmd       (cmd)
   );

   svk_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .x_elem       (req.x_elem),
      .y_elem       (req.y_elem),
      .cmd          (cmd),
      .status       (status),
      .kernel_value (rsp.kernel_value),
      .saturated    (rsp.saturated)
   );

   assign req.ready = req_ready;
   assign rsp.valid = rsp_valid;

endmodule
`default_nettype wire
